@@ design/vrpa_pkg.sv @@
// Shared constants, codes and control/status structs of the region pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package vrpa_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_REGIONS = 512;

    localparam int ADDR_W     = 32;
    localparam int PAGES_W    = 21;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
    // page count of a rounded request: (size + PAGE_BYTES - 1) >> PAGE_SHIFT
    localparam int RP_W       = ADDR_W + 1 - PAGE_SHIFT;
    localparam int BYTES_W    = PAGES_W + PAGE_SHIFT;
    localparam int REL_W      = (BYTES_W >= ADDR_W) ? BYTES_W + 1 : ADDR_W + 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'h4000_0000;
    localparam logic [ADDR_W-1:0] POOL_SIZE_RST = 32'h0040_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE = 1'b0,
        CFG_POOL_SIZE = 1'b1
    } cfg_reg_e_t;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_LEGIT   = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_NEXT,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_ALLOC,
        RES_NOSPACE,
        RES_FULL,
        RES_UNKNOWN,
        RES_RELEASE,
        RES_LEGIT,
        RES_NONE
    } res_op_t;

    typedef struct packed {
        logic    load_req;
        logic    idx_one;
        logic    idx_inc;
        rd_sel_t rd_sel;
        logic    wr_alloc;
        logic    wr_shift;
        logic    hit_latch;
        logic    rel_commit;
        logic    res_load;
        res_op_t res_op;
    } vrpa_cmd_t;

    typedef struct packed {
        req_type_t req_type;
        logic      no_space;
        logic      table_full;
        logic      scan_end;
        logic      base_hit;
        logic      shift_end;
    } vrpa_stat_t;

endpackage

`default_nettype wire

@@ design/vrpa_dpath.sv @@
// Datapath: pool registers, region table memory, counters and result registers.
`timescale 1ns / 1ps
`default_nettype none

module vrpa_dpath (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire vrpa_pkg::vrpa_cmd_t              cmd,
    output vrpa_pkg::vrpa_stat_t                  stat,
    input  wire  [1:0]                            req_type,
    input  wire  [vrpa_pkg::ADDR_W-1:0]           req_size,
    input  wire  [vrpa_pkg::ADDR_W-1:0]           req_address,
    input  wire                                   cfg_we,
    input  wire  [vrpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [vrpa_pkg::ADDR_W-1:0]           cfg_data,
    output logic [1:0]                            status,
    output logic [vrpa_pkg::ADDR_W-1:0]           alloc_base,
    output logic [vrpa_pkg::ADDR_W-1:0]           freed_base,
    output logic [vrpa_pkg::PAGES_W-1:0]          freed_pages,
    output logic                                  legit
);

    localparam int AW = vrpa_pkg::ADDR_W;
    localparam int PW = vrpa_pkg::PAGES_W;
    localparam int CW = vrpa_pkg::CNT_W;
    localparam int IW = vrpa_pkg::IDX_W;
    localparam int SH = vrpa_pkg::PAGE_SHIFT;
    localparam int RW = vrpa_pkg::REL_W;

    localparam logic [AW-1:0] POOL_BASE_RST_L = vrpa_pkg::POOL_BASE_RST;
    localparam logic [AW-1:0] POOL_SIZE_RST_L = vrpa_pkg::POOL_SIZE_RST;

    // region table
    logic [AW-1:0] region_base_mem  [vrpa_pkg::MAX_REGIONS];
    logic [PW-1:0] region_pages_mem [vrpa_pkg::MAX_REGIONS];

    logic [AW-1:0]               pool_base_reg, pool_base_next;
    logic [AW-1:0]               pool_size_reg, pool_size_next;
    logic [AW-1:0]               free_reg, free_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               idx_reg, idx_next;
    vrpa_pkg::req_type_t         req_type_reg;
    logic [vrpa_pkg::RP_W-1:0]   req_pages_reg;
    logic [AW-1:0]               req_addr_reg;
    logic [PW-1:0]               hit_pages_reg;
    logic [AW-1:0]               rd_base_reg;
    logic [PW-1:0]               rd_pages_reg;

    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] alloc_base_reg, alloc_base_next;
    logic [AW-1:0] freed_base_reg, freed_base_next;
    logic [PW-1:0] freed_pages_reg, freed_pages_next;
    logic          legit_reg, legit_next;

    logic [AW:0]   size_round;
    logic [AW:0]   req_bytes;
    logic [CW-1:0] idx_plus;
    logic [CW-1:0] last_idx;
    logic [AW-1:0] last_base;
    logic [PW-1:0] last_pages;
    logic [AW-1:0] new_base;
    logic [RW-1:0] rel_sum;
    logic [AW:0]   pool_end;
    logic          in_pool;
    logic [AW-1:0] cfg_size;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [AW-1:0] wr_base;
    logic [PW-1:0] wr_pages;
    logic [IW-1:0] rd_addr;

    assign size_round = {1'b0, req_size} + (AW+1)'(vrpa_pkg::PAGE_BYTES - 1);
    assign req_bytes  = {req_pages_reg, {SH{1'b0}}};
    assign idx_plus   = idx_reg + CW'(1);
    assign last_idx   = count_reg - CW'(1);

    // entry 0 is the metadata page and lives in the pool registers, not the memory
    assign last_base  = (count_reg == CW'(1)) ? pool_base_reg : rd_base_reg;
    assign last_pages = (count_reg == CW'(1)) ? PW'(1) : rd_pages_reg;
    assign new_base   = last_base + AW'({last_pages, {SH{1'b0}}});

    assign rel_sum  = RW'(free_reg) + RW'({hit_pages_reg, {SH{1'b0}}});
    assign pool_end = {1'b0, pool_base_reg} + {1'b0, pool_size_reg};
    assign in_pool  = (req_addr_reg >= pool_base_reg) && ({1'b0, req_addr_reg} < pool_end);

    assign stat.req_type   = req_type_reg;
    assign stat.no_space   = req_bytes > {1'b0, free_reg};
    assign stat.table_full = count_reg >= CW'(vrpa_pkg::MAX_REGIONS);
    assign stat.scan_end   = idx_reg >= count_reg;
    assign stat.base_hit   = rd_base_reg == req_addr_reg;
    assign stat.shift_end  = idx_plus >= count_reg;

    // memory ports
    always_comb
    begin
        mem_we   = cmd.wr_alloc || cmd.wr_shift;
        wr_addr  = cmd.wr_alloc ? count_reg[IW-1:0] : idx_reg[IW-1:0];
        wr_base  = cmd.wr_alloc ? new_base : rd_base_reg;
        wr_pages = cmd.wr_alloc ? PW'(req_pages_reg) : rd_pages_reg;
        unique case (cmd.rd_sel)
            vrpa_pkg::RD_IDX:  rd_addr = idx_reg[IW-1:0];
            vrpa_pkg::RD_NEXT: rd_addr = idx_plus[IW-1:0];
            vrpa_pkg::RD_LAST: rd_addr = last_idx[IW-1:0];
            vrpa_pkg::RD_NONE: rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            region_base_mem[wr_addr]  <= wr_base;
            region_pages_mem[wr_addr] <= wr_pages;
        end
        if (cmd.rd_sel != vrpa_pkg::RD_NONE)
        begin
            rd_base_reg  <= region_base_mem[rd_addr];
            rd_pages_reg <= region_pages_mem[rd_addr];
        end
    end

    // pool state and counters
    always_comb
    begin
        pool_base_next = pool_base_reg;
        pool_size_next = pool_size_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cfg_size       = pool_size_reg;
        if (cfg_we)
        begin
            if (cfg_index == vrpa_pkg::CFG_POOL_BASE)
                pool_base_next = cfg_data;
            else
            begin
                pool_size_next = cfg_data;
                cfg_size       = cfg_data;
            end
            count_next = CW'(1);
            free_next  = (cfg_size >= AW'(vrpa_pkg::PAGE_BYTES))
                         ? cfg_size - AW'(vrpa_pkg::PAGE_BYTES) : '0;
        end
        else if (cmd.wr_alloc)
        begin
            count_next = count_reg + CW'(1);
            free_next  = free_reg - req_bytes[AW-1:0];
        end
        else if (cmd.rel_commit)
        begin
            count_next = last_idx;
            free_next  = (rel_sum > RW'({AW{1'b1}})) ? {AW{1'b1}} : rel_sum[AW-1:0];
        end
        if (cmd.idx_one)
            idx_next = CW'(1);
        else if (cmd.idx_inc)
            idx_next = idx_plus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RST_L;
            pool_size_reg <= POOL_SIZE_RST_L;
            free_reg      <= POOL_SIZE_RST_L - AW'(vrpa_pkg::PAGE_BYTES);
            count_reg     <= CW'(1);
            idx_reg       <= CW'(1);
        end
        else
        begin
            pool_base_reg <= pool_base_next;
            pool_size_reg <= pool_size_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    // request and result payload
    always_comb
    begin
        status_next      = vrpa_pkg::ST_OK;
        alloc_base_next  = '0;
        freed_base_next  = '0;
        freed_pages_next = '0;
        legit_next       = 1'b0;
        unique case (cmd.res_op)
            vrpa_pkg::RES_ALLOC:   alloc_base_next = new_base;
            vrpa_pkg::RES_NOSPACE: status_next = vrpa_pkg::ST_NOSPACE;
            vrpa_pkg::RES_FULL:    status_next = vrpa_pkg::ST_FULL;
            vrpa_pkg::RES_UNKNOWN: status_next = vrpa_pkg::ST_UNKNOWN;
            vrpa_pkg::RES_RELEASE:
            begin
                freed_base_next  = req_addr_reg;
                freed_pages_next = hit_pages_reg;
            end
            vrpa_pkg::RES_LEGIT:   legit_next = in_pool;
            vrpa_pkg::RES_NONE:    status_next = vrpa_pkg::ST_OK;
            default:               status_next = vrpa_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg  <= vrpa_pkg::req_type_t'(req_type);
            req_pages_reg <= size_round[AW:SH];
            req_addr_reg  <= req_address;
        end
        if (cmd.hit_latch)
            hit_pages_reg <= rd_pages_reg;
        if (cmd.res_load)
        begin
            status_reg      <= status_next;
            alloc_base_reg  <= alloc_base_next;
            freed_base_reg  <= freed_base_next;
            freed_pages_reg <= freed_pages_next;
            legit_reg       <= legit_next;
        end
    end

    assign status      = status_reg;
    assign alloc_base  = alloc_base_reg;
    assign freed_base  = freed_base_reg;
    assign freed_pages = freed_pages_reg;
    assign legit       = legit_reg;

endmodule

`default_nettype wire

@@ design/vrpa_ctrl.sv @@
// Controller: sequences allocate, table scan and table compaction.
`timescale 1ns / 1ps
`default_nettype none

module vrpa_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    output logic                       done,
    output vrpa_pkg::vrpa_cmd_t        cmd,
    input  wire vrpa_pkg::vrpa_stat_t  stat
);

    typedef enum logic [2:0] {
        IDLE,
        DISPATCH,
        ALLOC_WR,
        SCAN_RD,
        SCAN_CHK,
        SHIFT_RD,
        SHIFT_WR
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = vrpa_pkg::RD_NONE;
        cmd.res_op = vrpa_pkg::RES_NONE;
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    busy_next    = 1'b1;
                    state_next   = DISPATCH;
                end
            end
            DISPATCH:
            begin
                unique case (stat.req_type)
                    vrpa_pkg::REQ_ALLOC:
                    begin
                        // space check ranks above the table-full check
                        if (stat.no_space)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_op   = vrpa_pkg::RES_NOSPACE;
                        end
                        else if (stat.table_full)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_op   = vrpa_pkg::RES_FULL;
                        end
                        else
                        begin
                            cmd.rd_sel = vrpa_pkg::RD_LAST;
                            state_next = ALLOC_WR;
                        end
                    end
                    vrpa_pkg::REQ_RELEASE:
                    begin
                        cmd.idx_one = 1'b1;
                        state_next  = SCAN_RD;
                    end
                    vrpa_pkg::REQ_LEGIT:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_op   = vrpa_pkg::RES_LEGIT;
                    end
                    vrpa_pkg::REQ_NONE:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_op   = vrpa_pkg::RES_NONE;
                    end
                endcase
            end
            ALLOC_WR:
            begin
                cmd.wr_alloc = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_op   = vrpa_pkg::RES_ALLOC;
            end
            SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_op   = vrpa_pkg::RES_UNKNOWN;
                end
                else
                begin
                    cmd.rd_sel = vrpa_pkg::RD_IDX;
                    state_next = SCAN_CHK;
                end
            end
            SCAN_CHK:
            begin
                if (stat.base_hit)
                begin
                    cmd.hit_latch = 1'b1;
                    state_next    = SHIFT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = SCAN_RD;
                end
            end
            SHIFT_RD:
            begin
                if (stat.shift_end)
                begin
                    cmd.rel_commit = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_op     = vrpa_pkg::RES_RELEASE;
                end
                else
                begin
                    cmd.rd_sel = vrpa_pkg::RD_NEXT;
                    state_next = SHIFT_WR;
                end
            end
            SHIFT_WR:
            begin
                // entry idx+1 moves down into idx
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = SHIFT_RD;
            end
        endcase

        if (cmd.res_load)
        begin
            done_next  = 1'b1;
            busy_next  = 1'b0;
            state_next = IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ design/virtual_region_pool_allocator.sv @@
// Top level of the virtual region pool allocator: controller plus datapath.
//
//  channel   handshake               payload
//  request   start & !busy           req_type, req_size, req_address
//  result    done (one cycle)        status, alloc_base, freed_base, freed_pages, legit
//  config    cfg_we                  cfg_index, cfg_data
//
// Legitimacy checks and failed allocates give done from the dispatch state; a good
// allocate first reads the last entry, then writes the new one. Release walks and
// compacts the table through its single-read-port memory, entry by entry.
// Reset restores the default pool with only the metadata entry; the table needs
// no clearing pass. done is not held off; a new request is taken in its cycle.
`timescale 1ns / 1ps
`default_nettype none

module virtual_region_pool_allocator (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [1:0]                         req_type,
    input  wire  [vrpa_pkg::ADDR_W-1:0]        req_size,
    input  wire  [vrpa_pkg::ADDR_W-1:0]        req_address,
    input  wire                                cfg_we,
    input  wire  [vrpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [vrpa_pkg::ADDR_W-1:0]        cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [vrpa_pkg::ADDR_W-1:0]        alloc_base,
    output logic [vrpa_pkg::ADDR_W-1:0]        freed_base,
    output logic [vrpa_pkg::PAGES_W-1:0]       freed_pages,
    output logic                               legit
);

    vrpa_pkg::vrpa_cmd_t  cmd;
    vrpa_pkg::vrpa_stat_t stat;

    vrpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    vrpa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .req_size    (req_size),
        .req_address (req_address),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .alloc_base  (alloc_base),
        .freed_base  (freed_base),
        .freed_pages (freed_pages),
        .legit       (legit)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the virtual region pool allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;

    import vrpa_pkg::*;

    typedef enum {MIX_NORMAL, MIX_FILL, MIX_CHURN} stim_mix_t;

    typedef struct {
        req_type_t          op;
        status_t            status;
        logic [ADDR_W-1:0]  alloc_base;
        logic [ADDR_W-1:0]  freed_base;
        logic [PAGES_W-1:0] freed_pages;
        logic               legit;
    } pool_result_t;

    // Predicts the pool table and checks each done strobe against the oldest request.
    class pool_result_checker;
        logic [ADDR_W-1:0]  pool_base;
        logic [ADDR_W-1:0]  pool_size;
        logic [ADDR_W-1:0]  region_base [MAX_REGIONS];
        logic [PAGES_W-1:0] region_pages [MAX_REGIONS];
        int                 region_cnt;
        logic [ADDR_W-1:0]  free_bytes;
        pool_result_t       pending_results [$];
        int                 errors;
        int                 checked;
        int                 op_count [4];
        int                 status_seen [4];

        function new();
            pool_base = POOL_BASE_RST;
            pool_size = POOL_SIZE_RST;
            errors    = 0;
            checked   = 0;
            foreach (op_count[k])
                op_count[k] = 0;
            foreach (status_seen[k])
                status_seen[k] = 0;
            reinit();
        endfunction

        function void reinit();
            region_base[0]  = pool_base;
            region_pages[0] = 1;
            region_cnt      = 1;
            free_bytes      = (pool_size >= PAGE_BYTES) ? pool_size - PAGE_BYTES : '0;
        endfunction

        // any register write rebuilds the pool with only the metadata entry
        function void write_reg(cfg_reg_e_t idx, logic [ADDR_W-1:0] val);
            if (idx == CFG_POOL_BASE)
                pool_base = val;
            else
                pool_size = val;
            reinit();
        endfunction

        function void take_request(req_type_t op, logic [ADDR_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            pool_result_t    r;
            longint unsigned npages;
            longint unsigned nbytes;
            longint unsigned sum;
            longint unsigned pool_end;
            int              hit;
            int              i;
            r.op          = op;
            r.status      = ST_OK;
            r.alloc_base  = '0;
            r.freed_base  = '0;
            r.freed_pages = '0;
            r.legit       = 1'b0;
            op_count[op]++;
            case (op)
                REQ_ALLOC:
                begin
                    npages = ({32'd0, size} + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
                    nbytes = npages * 64'(PAGE_BYTES);
                    // space is checked before the table
                    if (nbytes > {32'd0, free_bytes})
                        r.status = ST_NOSPACE;
                    else if (region_cnt >= MAX_REGIONS)
                        r.status = ST_FULL;
                    else
                    begin
                        r.alloc_base = region_base[region_cnt-1] +
                                       32'(region_pages[region_cnt-1]) * 32'(PAGE_BYTES);
                        region_base[region_cnt]  = r.alloc_base;
                        region_pages[region_cnt] = npages[PAGES_W-1:0];
                        free_bytes = free_bytes - nbytes[ADDR_W-1:0];
                        region_cnt++;
                    end
                end
                REQ_RELEASE:
                begin
                    hit = 0;
                    for (i = 1; i < region_cnt && hit == 0; i++)
                        if (region_base[i] == addr)
                            hit = i;
                    if (hit == 0)
                        r.status = ST_UNKNOWN;
                    else
                    begin
                        // length of the released entry, taken before compaction
                        r.freed_base  = addr;
                        r.freed_pages = region_pages[hit];
                        for (i = hit; i + 1 < region_cnt; i++)
                        begin
                            region_base[i]  = region_base[i+1];
                            region_pages[i] = region_pages[i+1];
                        end
                        region_cnt--;
                        sum = {32'd0, free_bytes} + 64'(r.freed_pages) * 64'(PAGE_BYTES);
                        free_bytes = (sum > 64'hFFFF_FFFF) ? '1 : sum[ADDR_W-1:0];
                    end
                end
                REQ_LEGIT:
                begin
                    pool_end = {32'd0, pool_base} + {32'd0, pool_size};
                    r.legit  = (addr >= pool_base) && ({32'd0, addr} < pool_end);
                end
                default:
                    ;
            endcase
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [1:0] st, logic [ADDR_W-1:0] ab, logic [ADDR_W-1:0] fb,
                          logic [PAGES_W-1:0] fp, logic lg);
            pool_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no request outstanding (status %0d)", st));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (st !== want.status)
                report($sformatf("%s status %0d, want %0d", want.op.name(), st, want.status));
            if (ab !== want.alloc_base)
                report($sformatf("%s alloc_base %h, want %h", want.op.name(), ab,
                                 want.alloc_base));
            if (fb !== want.freed_base)
                report($sformatf("%s freed_base %h, want %h", want.op.name(), fb,
                                 want.freed_base));
            if (fp !== want.freed_pages)
                report($sformatf("%s freed_pages %0d, want %0d", want.op.name(), fp,
                                 want.freed_pages));
            if (lg !== want.legit)
                report($sformatf("%s legit %b, want %b", want.op.name(), lg, want.legit));
        endtask
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [1:0]           req_type    = '0;
    logic [ADDR_W-1:0]    req_size    = '0;
    logic [ADDR_W-1:0]    req_address = '0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [ADDR_W-1:0]    cfg_data    = '0;
    logic                 done;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    alloc_base;
    logic [ADDR_W-1:0]    freed_base;
    logic [PAGES_W-1:0]   freed_pages;
    logic                 legit;

    pool_result_checker sb = new();
    int                 burst_left = 0;

    virtual_region_pool_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .req_size    (req_size),
        .req_address (req_address),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .alloc_base  (alloc_base),
        .freed_base  (freed_base),
        .freed_pages (freed_pages),
        .legit       (legit)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, alloc_base, freed_base, freed_pages, legit);
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sender works in bursts; a gap drives junk on the request fields with start low.
    task automatic send(req_type_t t, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] a);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                start       <= 1'b0;
                req_type    <= 2'($urandom);
                req_size    <= $urandom;
                req_address <= $urandom;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start       <= 1'b1;
        req_type    <= t;
        req_size    <= s;
        req_address <= a;
        do
            @(posedge clk);
        while (busy);
        sb.take_request(t, s, a);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        burst_left = 0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e_t idx, logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_size(stim_mix_t mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mix != MIX_NORMAL)
            // rare oversized requests always miss, so the table keeps filling
            return (r < 97) ? 32'($urandom_range(0, 4 * PAGE_BYTES))
                            : (32'hFFFF_F000 | $urandom);
        if (r < 30)
            return $urandom_range(0, 4 * PAGE_BYTES);
        if (r < 45)
            return $urandom_range(0, 8) * PAGE_BYTES;
        if (r < 55)
            return sb.free_bytes;
        if (r < 62)
            return sb.free_bytes + 1;
        if (r < 75)
            return $urandom;
        return $urandom_range(0, sb.free_bytes);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_release_addr();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80 && sb.region_cnt > 1)
            return sb.region_base[$urandom_range(1, sb.region_cnt - 1)];
        if (r < 86)
            return sb.pool_base;
        if (r < 93)
            return sb.region_base[sb.region_cnt-1] + 32'(PAGE_BYTES);
        return $urandom;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_check_addr();
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] sz;
        b  = sb.pool_base;
        sz = sb.pool_size;
        case ($urandom_range(0, 6))
            0: return b - 1;
            1: return b;
            2: return b + sz - 1;
            3: return b + sz;
            4: return b + $urandom_range(0, sz - 1);
            5: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(stim_mix_t mix);
        int unsigned       r;
        req_type_t         t;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        s = $urandom;
        a = $urandom;
        case (mix)
            MIX_FILL:
                t = (r < 96) ? REQ_ALLOC : (r < 98) ? REQ_RELEASE : REQ_LEGIT;
            MIX_CHURN:
                t = (r < 50) ? REQ_ALLOC : (r < 94) ? REQ_RELEASE
                  : (r < 98) ? REQ_LEGIT : REQ_NONE;
            default:
                t = (r < 40) ? REQ_ALLOC : (r < 75) ? REQ_RELEASE
                  : (r < 95) ? REQ_LEGIT : REQ_NONE;
        endcase
        if (t == REQ_ALLOC)
            s = pick_size(mix);
        else if (t == REQ_RELEASE)
            a = pick_release_addr();
        else if (t == REQ_LEGIT)
            a = pick_check_addr();
        send(t, s, a);
    endtask

    task automatic set_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
        wait_idle();
        if ($urandom_range(0, 1) != 0)
        begin
            write_reg(CFG_POOL_BASE, base);
            write_reg(CFG_POOL_SIZE, size);
        end
        else
        begin
            write_reg(CFG_POOL_SIZE, size);
            write_reg(CFG_POOL_BASE, base);
        end
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size, int items);
        set_pool(base, size);
        repeat (items)
        begin
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            random_request(MIX_NORMAL);
        end
    endtask

    task automatic directed_requests();
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] sz;
        b  = sb.pool_base;
        sz = sb.pool_size;
        send(REQ_LEGIT, $urandom, b - 1);
        send(REQ_LEGIT, $urandom, b);
        send(REQ_LEGIT, $urandom, b + sz - 1);
        send(REQ_LEGIT, $urandom, b + sz);
        send(REQ_LEGIT, 32'h0, 32'h0);
        send(REQ_LEGIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_ALLOC, 32'd0, 32'h0);
        send(REQ_ALLOC, 32'd1, 32'hFFFF_FFFF);
        send(REQ_ALLOC, PAGE_BYTES, 32'h0);
        send(REQ_ALLOC, PAGE_BYTES + 1, 32'h0);
        // zero-page and one-page entries share a base; the lower one goes first
        send(REQ_RELEASE, 32'h0, b + PAGE_BYTES);
        send(REQ_RELEASE, 32'h0, b + PAGE_BYTES);
        send(REQ_RELEASE, 32'hFFFF_FFFF, b);
        send(REQ_RELEASE, 32'hFFFF_FFFF, 32'h1234_5678);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 32'h0);
        send(REQ_ALLOC, sb.free_bytes, 32'h0);
        send(REQ_ALLOC, 32'd1, 32'h0);
        send(REQ_ALLOC, 32'd0, 32'h0);
        send(REQ_RELEASE, 32'h0, b + 2 * PAGE_BYTES);
        send(REQ_ALLOC, PAGE_BYTES, 32'h0);
    endtask

    initial
    begin
        int guard;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        run_phase(32'h0000_0000, 32'h0000_1000, 20);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 20);
        run_phase(32'hFFFF_FFFF, 32'h0001_0000, 20);

        // fill the table to its limit, then churn around the full mark
        set_pool(32'h1000_0000, 32'hFFFF_FFFF);
        guard = 0;
        while (sb.region_cnt < MAX_REGIONS && guard < 800)
        begin
            random_request(MIX_FILL);
            guard++;
        end
        repeat (40) random_request(MIX_CHURN);

        repeat (3)
            run_phase(($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'hFFFF_F000),
                      $urandom_range(PAGE_BYTES, 64 * PAGE_BYTES), 20);
        run_phase(POOL_BASE_RST, POOL_SIZE_RST, 20);

        wait_idle();
        // a release over a full table walks and compacts every entry
        repeat (2 * MAX_REGIONS + 100) @(posedge clk);

        $display("requests: %0d allocate, %0d release, %0d address check, %0d unused type",
                 sb.op_count[REQ_ALLOC], sb.op_count[REQ_RELEASE], sb.op_count[REQ_LEGIT],
                 sb.op_count[REQ_NONE]);
        $display("results: %0d checked (ok %0d, no space %0d, unknown %0d, full %0d)",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_NOSPACE],
                 sb.status_seen[ST_UNKNOWN], sb.status_seen[ST_FULL]);
        $display("errors: %0d", sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
